/* src/pia_pkg.sv */
// shared types and constants of the pulse instruction assembler
package pia_pkg;

  localparam int unsigned FreqW  = 48;
  localparam int unsigned PhaseW = 19;
  localparam int unsigned FtolW  = 32;
  localparam int unsigned DataW  = 20;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREQ_TOL  = 4'd0,
    CFG_PHASE_TOL = 4'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_CONTINUE   = 4'd0,
    OP_STOP       = 4'd1,
    OP_LOOP       = 4'd2,
    OP_END_LOOP   = 4'd3,
    OP_JSR        = 4'd4,
    OP_RTS        = 4'd5,
    OP_BRANCH     = 4'd6,
    OP_LONG_DELAY = 4'd7,
    OP_WAIT       = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FREQ_FULL  = 3'd1,
    ST_RX_FULL    = 3'd2,
    ST_TX_FULL    = 3'd3,
    ST_BAD_OPCODE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_FREQ,
    SEL_RX,
    SEL_TX
  } tab_sel_e;

  typedef struct packed {
    logic [FreqW-1:0]  frequency_uhz;
    logic              rx_on;
    logic [PhaseW-1:0] rx_phase_mdeg;
    logic              tx_on;
    logic [PhaseW-1:0] tx_phase_mdeg;
    logic [9:0]        ttl_outputs;
    logic [31:0]       length_ticks;
    logic [3:0]        opcode;
    logic [20:0]       instr_operand;
  } cmd_t;

  typedef struct packed {
    logic [23:0] control_word;
    logic [23:0] data_and_opcode;
    logic [31:0] delay_count;
    status_e     status;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_t;

endpackage

/* src/pia_if.sv */
// valid/ready channel interfaces for commands, results and configuration
interface pia_cmd_if;
  logic           valid;
  logic           ready;
  pia_pkg::cmd_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pia_res_if;
  logic           valid;
  logic           ready;
  pia_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pia_cfg_if;
  logic           valid;
  logic           ready;
  pia_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/pulse_instruction_assembler.sv */
// pulse instruction assembler top level: table lookup sequencer and word packing
//
//   channel  dir  payload                                   beat when
//   cmd_i    in   pulse command (frequency, phases, ttl...)  valid && ready
//   res_o    out  control word, data/opcode, delay, status   valid && ready
//   cfg_i    in   register index, write data                 valid && ready (always ready)
//
// a command is scanned table by table (frequency, rx, tx), one stored entry per
// step through the single shared abs-difference/tolerance unit until a match,
// with one more step per table that is off or ends without a match, then one
// commit step and one idle step in which the next command is taken
// cmd_i is ready only when no command is in work; a result waits in the output
// register while the next command is scanned, commit stalls until it is taken
// reset empties all three tables and sets both tolerances to 1
module pulse_instruction_assembler #(
  parameter int unsigned FREQ_DEPTH  = 16,
  parameter int unsigned PHASE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pia_cmd_if.sink    cmd_i,
  pia_res_if.source  res_o,
  pia_cfg_if.sink    cfg_i
);
  import pia_pkg::*;

  localparam int unsigned MaxD = (FREQ_DEPTH > PHASE_DEPTH) ? FREQ_DEPTH : PHASE_DEPTH;
  localparam int unsigned FIW  = (FREQ_DEPTH > 1) ? $clog2(FREQ_DEPTH) : 1;
  localparam int unsigned PIW  = (PHASE_DEPTH > 1) ? $clog2(PHASE_DEPTH) : 1;
  localparam int unsigned FCW  = $clog2(FREQ_DEPTH + 1);
  localparam int unsigned PCW  = $clog2(PHASE_DEPTH + 1);
  localparam int unsigned SCW  = $clog2(MaxD + 1);

  state_e   state_q, state_d;
  tab_sel_e sel_q, sel_d;
  logic [SCW-1:0] idx_q, idx_d;
  cmd_t cmd_q, cmd_d;

  logic [FreqW-1:0]  freq_tab_q [FREQ_DEPTH];
  logic [PhaseW-1:0] rx_tab_q   [PHASE_DEPTH];
  logic [PhaseW-1:0] tx_tab_q   [PHASE_DEPTH];
  logic [FCW-1:0] freq_used_q, freq_used_d;
  logic [PCW-1:0] rx_used_q, rx_used_d;
  logic [PCW-1:0] tx_used_q, tx_used_d;

  logic [SCW-1:0] f_idx_q, f_idx_d, r_idx_q, r_idx_d, t_idx_q, t_idx_d;
  logic f_app_q, f_app_d, r_app_q, r_app_d, t_app_q, t_app_d;
  logic f_full_q, f_full_d, r_full_q, r_full_d, t_full_q, t_full_d;

  logic [FtolW-1:0]  freq_tol_q;
  logic [PhaseW-1:0] phase_tol_q;

  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;
  logic wr_freq, wr_rx, wr_tx;

  // shared compare unit
  logic [FreqW-1:0] cmp_a, cmp_b, cmp_tol, cmp_diff;
  logic             cmp_match;

  assign cmp_diff  = (cmp_a >= cmp_b) ? (cmp_a - cmp_b) : (cmp_b - cmp_a);
  assign cmp_match = (cmp_diff <= cmp_tol);

  logic             cur_en;
  logic [SCW-1:0]   cur_used;
  logic             cur_room;
  logic [DataW-1:0] data;
  status_e          status;
  logic [3:0]       fi, ri, ti;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

  always_comb begin
    cmp_a    = cmd_q.frequency_uhz;
    cmp_b    = freq_tab_q[idx_q[FIW-1:0]];
    cmp_tol  = FreqW'(freq_tol_q);
    cur_en   = cmd_q.rx_on | cmd_q.tx_on;
    cur_used = SCW'(freq_used_q);
    cur_room = (freq_used_q < FCW'(FREQ_DEPTH));
    case (sel_q)
      SEL_RX: begin
        cmp_a    = FreqW'(cmd_q.rx_phase_mdeg);
        cmp_b    = FreqW'(rx_tab_q[idx_q[PIW-1:0]]);
        cmp_tol  = FreqW'(phase_tol_q);
        cur_en   = cmd_q.rx_on;
        cur_used = SCW'(rx_used_q);
        cur_room = (rx_used_q < PCW'(PHASE_DEPTH));
      end
      SEL_TX: begin
        cmp_a    = FreqW'(cmd_q.tx_phase_mdeg);
        cmp_b    = FreqW'(tx_tab_q[idx_q[PIW-1:0]]);
        cmp_tol  = FreqW'(phase_tol_q);
        cur_en   = cmd_q.tx_on;
        cur_used = SCW'(tx_used_q);
        cur_room = (tx_used_q < PCW'(PHASE_DEPTH));
      end
      default: ;
    endcase
  end

  always_comb begin
    case (opcode_e'(cmd_q.opcode))
      OP_LOOP:       data = cmd_q.instr_operand[DataW-1:0] - DataW'(1);
      OP_LONG_DELAY: data = cmd_q.instr_operand[DataW-1:0] - DataW'(2);
      OP_END_LOOP, OP_JSR, OP_BRANCH: data = cmd_q.instr_operand[DataW-1:0];
      default:       data = '0;
    endcase
    if (f_full_q) begin
      status = ST_FREQ_FULL;
    end else if (r_full_q) begin
      status = ST_RX_FULL;
    end else if (t_full_q) begin
      status = ST_TX_FULL;
    end else if (cmd_q.opcode > 4'(OP_WAIT)) begin
      status = ST_BAD_OPCODE;
    end else begin
      status = ST_OK;
    end
    fi = (status == ST_OK) ? 4'(f_idx_q) : 4'd0;
    ri = (status == ST_OK) ? 4'(r_idx_q) : 4'd0;
    ti = (status == ST_OK) ? 4'(t_idx_q) : 4'd0;
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    freq_used_d = freq_used_q;
    rx_used_d   = rx_used_q;
    tx_used_d   = tx_used_q;
    f_idx_d = f_idx_q;  r_idx_d = r_idx_q;  t_idx_d = t_idx_q;
    f_app_d = f_app_q;  r_app_d = r_app_q;  t_app_d = t_app_q;
    f_full_d = f_full_q; r_full_d = r_full_q; t_full_d = t_full_q;
    out_valid_d = out_valid_q & ~res_o.ready;
    res_d       = res_q;
    wr_freq     = 1'b0;
    wr_rx       = 1'b0;
    wr_tx       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.data;
          sel_d   = SEL_FREQ;
          idx_d   = '0;
          f_idx_d = '0; r_idx_d = '0; t_idx_d = '0;
          f_app_d = 1'b0; r_app_d = 1'b0; t_app_d = 1'b0;
          f_full_d = 1'b0; r_full_d = 1'b0; t_full_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        logic done;
        done = 1'b0;
        if (!cur_en) begin
          done = 1'b1;
        end else if (idx_q < cur_used) begin
          if (cmp_match) begin
            done = 1'b1;
            case (sel_q)
              SEL_RX:  r_idx_d = idx_q;
              SEL_TX:  t_idx_d = idx_q;
              default: f_idx_d = idx_q;
            endcase
          end else begin
            idx_d = idx_q + SCW'(1);
          end
        end else begin
          done = 1'b1;
          case (sel_q)
            SEL_RX: begin
              r_idx_d = idx_q; r_app_d = cur_room; r_full_d = ~cur_room;
            end
            SEL_TX: begin
              t_idx_d = idx_q; t_app_d = cur_room; t_full_d = ~cur_room;
            end
            default: begin
              f_idx_d = idx_q; f_app_d = cur_room; f_full_d = ~cur_room;
            end
          endcase
        end
        if (done) begin
          idx_d = '0;
          case (sel_q)
            SEL_FREQ: sel_d = SEL_RX;
            SEL_RX:   sel_d = SEL_TX;
            default:  state_d = S_COMMIT;
          endcase
        end
      end
      S_COMMIT: begin
        if (!out_valid_q || res_o.ready) begin
          if (status == ST_OK) begin
            wr_freq = f_app_q;
            wr_rx   = r_app_q;
            wr_tx   = t_app_q;
            if (f_app_q) freq_used_d = freq_used_q + FCW'(1);
            if (r_app_q) rx_used_d   = rx_used_q + PCW'(1);
            if (t_app_q) tx_used_d   = tx_used_q + PCW'(1);
          end
          res_d.control_word    = {fi, ti, ri, ~cmd_q.tx_on, ~cmd_q.rx_on,
                                   cmd_q.ttl_outputs};
          res_d.data_and_opcode = {data, cmd_q.opcode};
          res_d.delay_count     = cmd_q.length_ticks - 32'd3;
          res_d.status          = status;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= SEL_FREQ;
      idx_q       <= '0;
      freq_used_q <= '0;
      rx_used_q   <= '0;
      tx_used_q   <= '0;
      f_app_q <= 1'b0; r_app_q <= 1'b0; t_app_q <= 1'b0;
      f_full_q <= 1'b0; r_full_q <= 1'b0; t_full_q <= 1'b0;
      out_valid_q <= 1'b0;
      freq_tol_q  <= FtolW'(1);
      phase_tol_q <= PhaseW'(1);
    end else begin
      sel_q       <= sel_d;
      idx_q       <= idx_d;
      freq_used_q <= freq_used_d;
      rx_used_q   <= rx_used_d;
      tx_used_q   <= tx_used_d;
      f_app_q <= f_app_d; r_app_q <= r_app_d; t_app_q <= t_app_d;
      f_full_q <= f_full_d; r_full_q <= r_full_d; t_full_q <= t_full_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        if (cfg_i.data.index == CFG_FREQ_TOL) begin
          freq_tol_q <= cfg_i.data.wdata[FtolW-1:0];
        end else if (cfg_i.data.index == CFG_PHASE_TOL) begin
          phase_tol_q <= cfg_i.data.wdata[PhaseW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    f_idx_q <= f_idx_d;
    r_idx_q <= r_idx_d;
    t_idx_q <= t_idx_d;
    if (wr_freq) freq_tab_q[freq_used_q[FIW-1:0]] <= cmd_q.frequency_uhz;
    if (wr_rx)   rx_tab_q[rx_used_q[PIW-1:0]]     <= cmd_q.rx_phase_mdeg;
    if (wr_tx)   tx_tab_q[tx_used_q[PIW-1:0]]     <= cmd_q.tx_phase_mdeg;
  end

endmodule

/* src/pia_checker.sv */
// port-level assertions for the pulse instruction assembler, with bind
module pia_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cmd_valid_i,
  input logic          cmd_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input pia_pkg::res_t res_data_i
);
  import pia_pkg::*;

  // one command in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while another is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled result beat changed");

  // any error clears all three indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.status != ST_OK) |-> res_data_i.control_word[23:12] == 12'd0)
    else $error("table index set on error");

  // a channel that is off has index 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.control_word[11] |-> res_data_i.control_word[19:16] == 4'd0)
    else $error("tx index set with tx off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.control_word[10] |-> res_data_i.control_word[15:12] == 4'd0)
    else $error("rx index set with rx off");

endmodule

bind pulse_instruction_assembler pia_checker u_pia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
